>>> src/hsl_pkg.sv
// Shared types and fixed-point constants for the HSL to RGB converter.
// No dependencies; every other file in src imports this package.
`default_nettype none

package hsl_pkg;

   // Q0.16 fractions are held in 17 bits so that 1.0 (65536) fits.
   localparam int QW = 17;

   localparam logic [8:0]    HUE_CIRCLE   = 9'd360;
   localparam logic [8:0]    FRAC_ONE     = 9'd256;
   localparam logic [QW-1:0] Q_ONE        = 17'd65536;
   localparam logic [QW-1:0] Q_HALF       = 17'd32768;
   localparam logic [QW-1:0] Q_THIRD      = 17'd21845;
   localparam logic [QW-1:0] Q_TWO_THIRDS = 17'd43691;
   localparam logic [17:0]   Q_TWO        = 18'd131072;

   // floor(hue * 65536 / 360) = hue * 182 + floor(hue * 2914 / 65536) for hue < 360
   localparam logic [7:0]    HUE_STEP     = 8'd182;
   localparam logic [11:0]   HUE_FIX      = 12'd2914;

   localparam logic [7:0]    CHAN_MAX     = 8'd255;

   typedef struct packed {
      logic [8:0] hue;
      logic [8:0] saturation;
      logic [8:0] lightness;
   } hsl_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } hsl_rsp_type;

   // Load enables, one per pipeline stage.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } hsl_adv_type;

endpackage

`default_nettype wire

>>> src/hsl_prep.sv
// Stage 1: clamp the input pixel, scale to Q0.16 and form the L*S and hue products.
// Depends on hsl_pkg.
`default_nettype none

module hsl_prep import hsl_pkg::*; (
   input  wire logic              clock,
   input  wire logic              adv,
   input  wire hsl_req_type       req,
   output logic [QW-1:0]          l_ff,
   output logic [QW-1:0]          s_ff,
   output logic [QW-1:0]          p_ff,
   output logic [15:0]            hbase_ff,
   output logic [3:0]             hfix_ff
);

   logic [8:0]    hue_w;
   logic [8:0]    sat_c;
   logic [8:0]    lig_c;
   logic [QW-1:0] s_in;
   logic [QW-1:0] l_in;
   logic [33:0]   ls_prod;
   logic [16:0]   hbase_prod;
   logic [20:0]   hfix_prod;

   always_comb begin
      hue_w = (req.hue >= HUE_CIRCLE) ? (req.hue - HUE_CIRCLE) : req.hue;
      sat_c = (req.saturation > FRAC_ONE) ? FRAC_ONE : req.saturation;
      lig_c = (req.lightness > FRAC_ONE) ? FRAC_ONE : req.lightness;
      s_in  = {sat_c, 8'd0};
      l_in  = {lig_c, 8'd0};
      ls_prod    = {17'd0, l_in} * {17'd0, s_in};
      hbase_prod = {8'd0, hue_w} * {9'd0, HUE_STEP};
      hfix_prod  = {12'd0, hue_w} * {9'd0, HUE_FIX};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l_ff     <= l_in;
         s_ff     <= s_in;
         p_ff     <= ls_prod[32:16];
         hbase_ff <= hbase_prod[15:0];
         hfix_ff  <= hfix_prod[19:16];
      end
   end

endmodule

`default_nettype wire

>>> src/hsl_span.sv
// Stage 2: build the hue fraction, the upper and lower HSL values and the three offset hues.
// Depends on hsl_pkg.
`default_nettype none

module hsl_span import hsl_pkg::*; (
   input  wire logic              clock,
   input  wire logic              adv,
   input  wire logic [QW-1:0]     l,
   input  wire logic [QW-1:0]     s,
   input  wire logic [QW-1:0]     p,
   input  wire logic [15:0]       hbase,
   input  wire logic [3:0]        hfix,
   output logic [QW-1:0]          v1_ff,
   output logic [QW-1:0]          d_ff,
   output logic [2:0][QW-1:0]     t_ff
);

   logic [QW-1:0]      h;
   logic [17:0]        v2_wide;
   logic [QW-1:0]      v2;
   logic [17:0]        two_l;
   logic [QW-1:0]      v1_in;
   logic [QW-1:0]      d_in;
   logic [17:0]        tr_wide;
   logic [2:0][QW-1:0] t_in;

   always_comb begin
      h = {1'b0, hbase} + {13'd0, hfix};
      if (l < Q_HALF) begin
         v2_wide = {1'b0, l} + {1'b0, p};
      end else begin
         v2_wide = {1'b0, l} + {1'b0, s} - {1'b0, p};
      end
      v2    = v2_wide[QW-1:0];
      two_l = {l, 1'b0};
      v1_in = (two_l > {1'b0, v2}) ? QW'(two_l - {1'b0, v2}) : '0;
      d_in  = (v2 > v1_in) ? (v2 - v1_in) : '0;

      // red: wrap past one turn; blue: wrap below zero
      tr_wide = {1'b0, h} + {1'b0, Q_THIRD};
      t_in[0] = (tr_wide > {1'b0, Q_ONE}) ? QW'(tr_wide - {1'b0, Q_ONE})
                                            : tr_wide[QW-1:0];
      t_in[1] = h;
      t_in[2] = (h >= Q_THIRD) ? (h - Q_THIRD) : (h + Q_TWO_THIRDS);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v1_ff <= v1_in;
         d_ff  <= d_in;
         t_ff  <= t_in;
      end
   end

endmodule

`default_nettype wire

>>> src/hsl_ramp.sv
// Stages 3 and 4 for one color channel: piecewise hue ramp, then scale to 8 bits.
// Depends on hsl_pkg.
`default_nettype none

module hsl_ramp import hsl_pkg::*; (
   input  wire logic              clock,
   input  wire logic              adv3,
   input  wire logic              adv4,
   input  wire logic [QW-1:0]     t,
   input  wire logic [QW-1:0]     v1,
   input  wire logic [QW-1:0]     d,
   output logic [7:0]             chan_ff
);

   logic [19:0]   six_t;
   logic [18:0]   three_t;
   logic [QW-1:0] k;
   logic [19:0]   six_k;
   logic [QW-1:0] m;
   logic [33:0]   prod;
   logic [17:0]   add_ff;
   logic [QW-1:0] v1_ff;
   logic [18:0]   v;
   logic [26:0]   scaled;
   logic [7:0]    chan_in;

   // Stage 3: pick the ramp slope factor; the flat top is d * 1.0
   always_comb begin
      six_t   = ({3'd0, t} << 2) + ({3'd0, t} << 1);
      three_t = {2'd0, t} + {1'b0, t, 1'b0};
      k       = (Q_TWO_THIRDS > t) ? (Q_TWO_THIRDS - t) : '0;
      six_k   = ({3'd0, k} << 2) + ({3'd0, k} << 1);
      priority if (six_t < {3'd0, Q_ONE}) begin
         m = six_t[QW-1:0];
      end else if (t < Q_HALF) begin
         m = Q_ONE;
      end else if (three_t < {1'b0, Q_TWO}) begin
         m = six_k[QW-1:0];
      end else begin
         m = '0;
      end
      prod = {17'd0, d} * {17'd0, m};
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         add_ff <= prod[33:16];
         v1_ff  <= v1;
      end
   end

   // Stage 4: value * 255 / 65536, saturate
   always_comb begin
      v       = {2'd0, v1_ff} + {1'b0, add_ff};
      scaled  = ({8'd0, v} << 8) - {8'd0, v};
      chan_in = (scaled[26:16] > {3'd0, CHAN_MAX}) ? CHAN_MAX : scaled[23:16];
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         chan_ff <= chan_in;
      end
   end

endmodule

`default_nettype wire

>>> src/hsl_to_rgb_converter.sv
// Top level of the HSL to RGB pixel converter: stage valid bits, flow control, datapath.
// Depends on hsl_pkg, hsl_prep, hsl_span and hsl_ramp.
//
//   channel   ports                          beat contents
//   --------  -----------------------------  -------------------------------------
//   req       req_valid/req_ready/req_data   hue (deg), saturation, lightness (/256)
//   rsp       rsp_valid/rsp_ready/rsp_data   red, green, blue (8 bits each)
//
// Four register stages: clamp and products, HSL span and offset hues, ramp
// multiply per channel, scale to 8 bits into the output register. One beat
// enters per cycle while the rsp side does not stall.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// collapse and a stalled rsp side holds all data in place without loss.
// Reset clears only the stage valid bits.
// Zero saturation needs no special path: v1 = v2 = lightness gives gray.
`default_nettype none

module hsl_to_rgb_converter import hsl_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire hsl_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output hsl_rsp_type      rsp_data
);

   logic [3:0]         valid_ff;
   logic [3:0]         valid_in;
   hsl_adv_type        adv;

   logic [QW-1:0]      l_ff;
   logic [QW-1:0]      s_ff;
   logic [QW-1:0]      p_ff;
   logic [15:0]        hbase_ff;
   logic [3:0]         hfix_ff;
   logic [QW-1:0]      v1_ff;
   logic [QW-1:0]      d_ff;
   logic [2:0][QW-1:0] t_ff;
   logic [2:0][7:0]    chan_ff;

   // Advance a stage when it holds nothing or its successor advances.
   always_comb begin
      adv.s4 = !valid_ff[3] || rsp_ready;
      adv.s3 = !valid_ff[2] || adv.s4;
      adv.s2 = !valid_ff[1] || adv.s3;
      adv.s1 = !valid_ff[0] || adv.s2;

      valid_in[0] = adv.s1 ? req_valid   : valid_ff[0];
      valid_in[1] = adv.s2 ? valid_ff[0] : valid_ff[1];
      valid_in[2] = adv.s3 ? valid_ff[1] : valid_ff[2];
      valid_in[3] = adv.s4 ? valid_ff[2] : valid_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = adv.s1;
   assign rsp_valid = valid_ff[3];

   hsl_prep u_prep (
      .clock    (clock),
      .adv      (adv.s1),
      .req      (req_data),
      .l_ff     (l_ff),
      .s_ff     (s_ff),
      .p_ff     (p_ff),
      .hbase_ff (hbase_ff),
      .hfix_ff  (hfix_ff)
   );

   hsl_span u_span (
      .clock (clock),
      .adv   (adv.s2),
      .l     (l_ff),
      .s     (s_ff),
      .p     (p_ff),
      .hbase (hbase_ff),
      .hfix  (hfix_ff),
      .v1_ff (v1_ff),
      .d_ff  (d_ff),
      .t_ff  (t_ff)
   );

   // One ramp per channel: red, green, blue offset hues in that order.
   for (genvar i = 0; i < 3; i++) begin : g_chan
      hsl_ramp u_ramp (
         .clock   (clock),
         .adv3    (adv.s3),
         .adv4    (adv.s4),
         .t       (t_ff[i]),
         .v1      (v1_ff),
         .d       (d_ff),
         .chan_ff (chan_ff[i])
      );
   end

   always_comb begin
      rsp_data.red   = chan_ff[0];
      rsp_data.green = chan_ff[1];
      rsp_data.blue  = chan_ff[2];
   end

endmodule

`default_nettype wire
